// ----- hw/rtl/npd_pkg.sv -----
// Shared constants, types and controller/datapath interface for the nearest point distance scan.
package npd_pkg;

	localparam int MAX_TRAPS  = 1024;
	localparam int IDX_BITS   = $clog2(MAX_TRAPS);
	localparam int CNT_BITS   = IDX_BITS + 1;
	localparam int COORD_BITS = 20;
	localparam int PROD_BITS  = 2 * COORD_BITS;
	localparam int SQ_BITS    = PROD_BITS + 1;
	localparam int DIST_BITS  = 21;
	localparam int RAD_BITS   = 2 * DIST_BITS;
	localparam int REM_BITS   = DIST_BITS + 2;
	localparam int STEP_BITS  = $clog2(DIST_BITS);

	localparam logic [DIST_BITS-1:0] DIST_NONE = '1;

	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_SQRT,
		ST_DONE
	} npd_state_t;

	typedef struct packed {
		logic                wr_en;
		logic                q_load;
		logic                rd_en;
		logic [IDX_BITS-1:0] rd_addr;
		logic                sqrt_load;
		logic                sqrt_step;
		logic                out_load;
		logic                out_none;
	} npd_cmd_t;

	typedef struct packed {
		logic pipe_busy;
		logic out_free;
	} npd_sts_t;

endpackage

// ----- hw/rtl/npd_ctrl.sv -----
// Controller state machine: input handshake, trap count register, scan and root sequencing.
module npd_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     mode,
	output logic                     in_stall,
	input  logic                     cfg_valid,
	input  logic                     cfg_ready,
	input  logic [npd_pkg::CNT_BITS-1:0] cfg_data,
	output npd_pkg::npd_cmd_t        cmd,
	input  npd_pkg::npd_sts_t        sts
);
	import npd_pkg::*;

	npd_state_t          state_q;
	npd_state_t          state_d;
	logic [CNT_BITS-1:0] trap_count_q;
	logic [CNT_BITS-1:0] count_clamped;
	logic [CNT_BITS-1:0] scan_n_q;
	logic [CNT_BITS-1:0] idx_q;
	logic [STEP_BITS-1:0] step_q;
	logic                none_q;
	logic                accept;
	logic                scan_last;
	logic                sqrt_last;

	// Limit the scan to the store depth
	assign count_clamped = (trap_count_q > CNT_BITS'(MAX_TRAPS)) ?
		CNT_BITS'(MAX_TRAPS) : trap_count_q;
	assign accept    = in_valid && !in_stall;
	assign scan_last = (idx_q == scan_n_q - CNT_BITS'(1));
	assign sqrt_last = (step_q == STEP_BITS'(DIST_BITS - 1));

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && mode == MODE_QUERY) begin
					if (count_clamped == '0)
						state_d = ST_DONE;
					else
						state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_last)
					state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!sts.pipe_busy)
					state_d = ST_SQRT;
			end
			ST_SQRT: begin
				if (sqrt_last)
					state_d = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs and commands
	always_comb begin
		in_stall      = (state_q != ST_IDLE);
		cmd.wr_en     = accept && (mode == MODE_WRITE);
		cmd.q_load    = accept && (mode == MODE_QUERY);
		cmd.rd_en     = (state_q == ST_SCAN);
		cmd.rd_addr   = idx_q[IDX_BITS-1:0];
		cmd.sqrt_load = (state_q == ST_DRAIN) && !sts.pipe_busy;
		cmd.sqrt_step = (state_q == ST_SQRT);
		cmd.out_load  = (state_q == ST_DONE) && sts.out_free;
		cmd.out_none  = none_q;
	end

	// State and config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			trap_count_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready)
				trap_count_q <= cfg_data;
		end
	end

	// Advance scan index and root step counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			scan_n_q <= '0;
			step_q   <= '0;
			none_q   <= 1'b0;
		end else begin
			if (cmd.q_load) begin
				idx_q    <= '0;
				scan_n_q <= count_clamped;
				none_q   <= (count_clamped == '0);
			end else if (cmd.rd_en) begin
				idx_q <= idx_q + CNT_BITS'(1);
			end
			if (cmd.sqrt_load)
				step_q <= '0;
			else if (cmd.sqrt_step)
				step_q <= step_q + STEP_BITS'(1);
		end
	end

	a_sqrt_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SQRT) |-> !sts.pipe_busy)
		else $error("root started while scan pipeline still busy");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (idx_q < scan_n_q))
		else $error("scan index beyond trap count");

	a_done_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> (state_q == ST_IDLE))
		else $error("result loaded without returning to idle");

endmodule

// ----- hw/rtl/npd_datapath.sv -----
// Datapath: trap store, distance pipeline, minimum tracking, iterative square root, output register.
module npd_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  npd_pkg::npd_cmd_t            cmd,
	output npd_pkg::npd_sts_t            sts,
	input  logic [npd_pkg::IDX_BITS-1:0]   index,
	input  logic [npd_pkg::COORD_BITS-1:0] x_coord,
	input  logic [npd_pkg::COORD_BITS-1:0] y_coord,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [npd_pkg::DIST_BITS-1:0]  min_distance
);
	import npd_pkg::*;

	logic [COORD_BITS-1:0] trap_x_mem [MAX_TRAPS];
	logic [COORD_BITS-1:0] trap_y_mem [MAX_TRAPS];

	logic [COORD_BITS-1:0] qx_q, qy_q;
	logic [COORD_BITS-1:0] rx_s1, ry_s1;
	logic [COORD_BITS-1:0] dx_s2, dy_s2;
	logic [PROD_BITS-1:0]  sqx_s3, sqy_s3;
	logic [SQ_BITS-1:0]    sum_s4;
	logic                  v_s1, v_s2, v_s3, v_s4;
	logic [SQ_BITS-1:0]    best_q;
	logic                  any_q;
	logic [RAD_BITS-1:0]   rad_q;
	logic [REM_BITS-1:0]   rem_q;
	logic [DIST_BITS-1:0]  root_q;
	logic [REM_BITS-1:0]   rem_next;
	logic [REM_BITS-1:0]   trial;
	logic                  out_valid_q;
	logic [DIST_BITS-1:0]  out_q;

	assign sts.pipe_busy = v_s1 || v_s2 || v_s3 || v_s4;
	assign sts.out_free  = !out_valid_q || !out_stall;
	assign out_valid     = out_valid_q;
	assign min_distance  = out_q;

	// Trap store: write on a write word, registered read during the scan
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			trap_x_mem[index] <= x_coord;
			trap_y_mem[index] <= y_coord;
		end
		if (cmd.rd_en) begin
			rx_s1 <= trap_x_mem[cmd.rd_addr];
			ry_s1 <= trap_y_mem[cmd.rd_addr];
		end
	end

	// Hold the query point
	always_ff @(posedge clk) begin
		if (cmd.q_load) begin
			qx_q <= x_coord;
			qy_q <= y_coord;
		end
	end

	// Distance pipeline payload: absolute differences, squares, sum
	always_ff @(posedge clk) begin
		dx_s2  <= (qx_q >= rx_s1) ? (qx_q - rx_s1) : (rx_s1 - qx_q);
		dy_s2  <= (qy_q >= ry_s1) ? (qy_q - ry_s1) : (ry_s1 - qy_q);
		sqx_s3 <= PROD_BITS'(dx_s2) * PROD_BITS'(dx_s2);
		sqy_s3 <= PROD_BITS'(dy_s2) * PROD_BITS'(dy_s2);
		sum_s4 <= SQ_BITS'(sqx_s3) + SQ_BITS'(sqy_s3);
	end

	// Distance pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= cmd.rd_en;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Keep the smallest squared distance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_q <= 1'b0;
		end else if (cmd.q_load) begin
			any_q <= 1'b0;
		end else if (v_s4) begin
			any_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s4 && (!any_q || sum_s4 < best_q))
			best_q <= sum_s4;
	end

	// Square root, two radicand bits per step
	assign rem_next = {rem_q[REM_BITS-3:0], rad_q[RAD_BITS-1 -: 2]};
	assign trial    = {root_q, 2'b01};

	always_ff @(posedge clk) begin
		if (cmd.sqrt_load) begin
			rad_q  <= RAD_BITS'(best_q);
			rem_q  <= '0;
			root_q <= '0;
		end else if (cmd.sqrt_step) begin
			rad_q <= {rad_q[RAD_BITS-3:0], 2'b00};
			if (rem_next >= trial) begin
				rem_q  <= rem_next - trial;
				root_q <= {root_q[DIST_BITS-2:0], 1'b1};
			end else begin
				rem_q  <= rem_next;
				root_q <= {root_q[DIST_BITS-2:0], 1'b0};
			end
		end
	end

	// Output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load)
			out_q <= cmd.out_none ? DIST_NONE : root_q;
	end

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || !out_stall))
		else $error("output word overwritten while stalled");

	a_first_sets_best: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && !cmd.q_load) |=> any_q)
		else $error("scanned distance not recorded");

endmodule

// ----- hw/rtl/nearest_point_distance_scan.sv -----
// Top level of the nearest point distance scan: controller and datapath.
//
// Usage:
//  - Input channel (in_valid / in_stall) carries mode, index, x_coord, y_coord.
//    A word with mode 0 stores a trap point at index; it returns no result.
//    A word with mode 1 queries a point.
//  - A query scans trap slots 0 .. trap_count-1 (at most 1024), one slot per
//    cycle through the store read register and the difference, square and
//    sum stages, then runs a bit-serial square root of 21 steps. A query
//    stalls the input until its result is loaded into the output register; a
//    query with trap_count 0 returns all ones. One word is worked on at a time.
//  - Output channel (out_valid / out_stall) returns min_distance, one word per
//    query, from an output register; the next input word is taken while a
//    result still waits there.
//  - Configuration channel (cfg_valid / cfg_ready) writes trap_count, is always
//    ready; the user writes it while the block is idle, which is not enforced.
//  - Reset (arst_n low) clears the state machine, the trap count and the
//    output valid. The trap store is not cleared: write each slot before a
//    query scans it.
//  - A stalled result holds its value; the block then waits before loading
//    the next result and stalls its input until that result leaves.
module nearest_point_distance_scan (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         mode,
	input  logic [npd_pkg::IDX_BITS-1:0]   index,
	input  logic [npd_pkg::COORD_BITS-1:0] x_coord,
	input  logic [npd_pkg::COORD_BITS-1:0] y_coord,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [npd_pkg::DIST_BITS-1:0]  min_distance,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [npd_pkg::CNT_BITS-1:0]   cfg_data
);
	import npd_pkg::*;

	npd_cmd_t cmd;
	npd_sts_t sts;

	// Accept register writes in any cycle
	assign cfg_ready = 1'b1;

	npd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.mode      (mode),
		.in_stall  (in_stall),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts)
	);

	npd_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.index        (index),
		.x_coord      (x_coord),
		.y_coord      (y_coord),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.min_distance (min_distance)
	);

endmodule
